// ===== rtl/m3i_pkg.sv =====
// Shared types and constants of the 3x3 matrix inverse pipeline.
// Depends on nothing; every file of the block but the three channel interfaces uses it.
package m3i_pkg;

  localparam int unsigned DW    = 32;  // Q16.16 entry
  localparam int unsigned CofW  = 65;  // exact cofactor, Q33.32 signed
  localparam int unsigned MagW  = 64;  // cofactor magnitude
  localparam int unsigned DetW  = 97;  // exact determinant, Q49.48 signed
  localparam int unsigned DmagW = 96;  // determinant magnitude
  localparam int unsigned DenW  = 97;  // divisor, twice the magnitude
  localparam int unsigned NumW  = 98;  // rounded dividend
  localparam int unsigned QB    = 33;  // quotient bits formed by the divider
  localparam int unsigned EpsW  = 31;

  localparam logic [DW-1:0] QOne   = 32'h0001_0000;
  localparam logic [DW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SatNeg = 32'h8000_0000;

  // Operand entries (p, q, r, s) of each adjugate entry p*q - r*s, row-major.
  localparam int unsigned CofSel [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic [8:0][DW-1:0]   mat_t;
  typedef logic [2:0][DW-1:0]   row_t;
  typedef logic [8:0][CofW-1:0] cof_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QB-1:0]   nlo;
    logic [QB-1:0]   quo;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]     lane;
    logic [DenW-1:0] den;
    logic            sing;
    logic [DW-1:0]   det;
  } div_t;

  typedef struct packed {
    logic [8:0][DW-1:0] b;
    logic               sing;
    logic [DW-1:0]      det;
  } res_t;

endpackage

// ===== rtl/m3i_in_if.sv =====
// Input channel of the matrix inverse: one 3x3 Q16.16 matrix per request.
// Stands alone; used by the top level.
interface m3i_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

// ===== rtl/m3i_out_if.sv =====
// Output channel of the matrix inverse: inverse, singular flag, determinant.
// Stands alone; used by the top level.
interface m3i_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic               singular;
  logic signed [31:0] det_value;

  modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  singular, det_value, input ready);
  modport sink   (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  singular, det_value, output ready);
endinterface

// ===== rtl/m3i_cfg_if.sv =====
// Configuration write channel of the matrix inverse: the epsilon register.
// Stands alone; used by the top level.
interface m3i_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] epsilon;

  modport source (output valid, epsilon, input ready);
  modport sink   (input valid, epsilon, output ready);
endinterface

// ===== rtl/m3i_cofactor.sv =====
// Two pipeline stages: the eighteen 32x32 products, then the nine cofactors.
// Depends on m3i_pkg.
module m3i_cofactor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  m3i_pkg::mat_t  mat_i,
  output logic           valid_o,
  input  logic           ready_i,
  output m3i_pkg::cof_t  cof_o,
  output m3i_pkg::row_t  row_o
);

  logic               v1_q, v2_q, en1, en2;
  logic [8:0][63:0]   pq_q, rs_q;
  logic signed [63:0] pq_d [9];
  logic signed [63:0] rs_d [9];
  m3i_pkg::row_t      row1_q, row2_q;
  m3i_pkg::cof_t      cof_d, cof_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign cof_o   = cof_q;
  assign row_o   = row2_q;

  for (genvar i = 0; i < 9; i++) begin : g_cof
    assign pq_d[i] = $signed(mat_i[m3i_pkg::CofSel[i][0]])
                   * $signed(mat_i[m3i_pkg::CofSel[i][1]]);
    assign rs_d[i] = $signed(mat_i[m3i_pkg::CofSel[i][2]])
                   * $signed(mat_i[m3i_pkg::CofSel[i][3]]);
    assign cof_d[i] = {pq_q[i][63], pq_q[i]} - {rs_q[i][63], rs_q[i]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 9; i++) begin
        pq_q[i] <= pq_d[i];
        rs_q[i] <= rs_d[i];
      end
      row1_q <= mat_i[2:0];
    end
    if (en2) begin
      cof_q  <= cof_d;
      row2_q <= row1_q;
    end
  end

endmodule

// ===== rtl/m3i_det.sv =====
// Five pipeline stages: determinant by first-row expansion, singular test,
// determinant output and the divider's starting operands. Depends on m3i_pkg.
module m3i_det (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  m3i_pkg::cof_t                 cof_i,
  input  m3i_pkg::row_t                 row_i,
  input  logic [m3i_pkg::EpsW-1:0]      eps_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output m3i_pkg::div_t                 div_o
);

  localparam int unsigned W  = m3i_pkg::DW;
  localparam int unsigned CW = m3i_pkg::CofW;
  localparam int unsigned MW = m3i_pkg::MagW;
  localparam int unsigned DT = m3i_pkg::DetW;
  localparam int unsigned DM = m3i_pkg::DmagW;
  localparam int unsigned NW = m3i_pkg::NumW;
  localparam int unsigned QB = m3i_pkg::QB;

  logic [4:0] v_q, en;

  // Stage 3: split products of |c| by |a| for the three first-row terms.
  m3i_pkg::cof_t      cof3_q, cof4_q, cof5_q;
  logic [2:0][63:0]   pl3_q, ph3_q, pl_d, ph_d;
  logic [2:0]         tneg3_q, tneg_d;
  // Stage 4: signed terms.  Stage 5: determinant.
  logic [2:0][DT-1:0] t4_q, t_d;
  logic [DT-1:0]      d5_q;
  // Stage 6: magnitudes, sign, singular flag, determinant output.
  logic [8:0][MW-1:0] cm6_q, cm_d;
  logic [8:0]         neg6_q, neg_d;
  logic [DM-1:0]      dm6_q;
  logic               sing6_q, sing_d;
  logic [W-1:0]       det6_q, det_d;
  logic [DT-1:0]      dabs;
  // Stage 7: divider start.
  m3i_pkg::div_t      div7_q, div_d;

  always_comb begin
    en[4] = !v_q[4] || ready_i;
    for (int k = 3; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[0];
  assign valid_o = v_q[4];
  assign div_o   = div7_q;

  for (genvar k = 0; k < 3; k++) begin : g_term
    logic [CW-1:0] c_full, cm_full;
    logic [W:0]    am_full;
    logic [DM-1:0] tmag;
    assign c_full  = cof_i[3*k];
    assign cm_full = c_full[CW-1] ? (~c_full + CW'(1)) : c_full;
    assign am_full = row_i[k][W-1] ? (~{1'b1, row_i[k]} + (W+1)'(1))
                                   : {1'b0, row_i[k]};
    assign pl_d[k]   = cm_full[31:0] * am_full[W-1:0];
    assign ph_d[k]   = cm_full[63:32] * am_full[W-1:0];
    assign tneg_d[k] = c_full[CW-1] ^ row_i[k][W-1];

    assign tmag   = {ph3_q[k], 32'b0} + {32'b0, pl3_q[k]};
    assign t_d[k] = tneg3_q[k] ? (~{1'b0, tmag} + DT'(1)) : {1'b0, tmag};
  end

  assign dabs   = d5_q[DT-1] ? (~d5_q + DT'(1)) : d5_q;
  assign sing_d = dabs[DM-1:0] <= {33'b0, eps_i, 32'b0};

  always_comb begin
    // Floor to Q16.16 keeps bits 63:32; it fits when bits 96:63 agree.
    if (&d5_q[DT-1:63] || ~|d5_q[DT-1:63]) det_d = d5_q[63:32];
    else if (d5_q[DT-1])                    det_d = m3i_pkg::SatNeg;
    else                                     det_d = m3i_pkg::SatPos;
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    logic [CW-1:0] cm_full;
    logic [NW-1:0] num;
    assign cm_full  = cof5_q[i][CW-1] ? (~cof5_q[i] + CW'(1)) : cof5_q[i];
    assign cm_d[i]  = cm_full[MW-1:0];
    assign neg_d[i] = cof5_q[i][CW-1] ^ d5_q[DT-1];

    // Rounded quotient is floor((2|c|*2^32 + |D|) / 2|D|).
    assign num = {1'b0, cm6_q[i], 33'b0} + {2'b0, dm6_q};
    assign div_d.lane[i].rem = {32'b0, num[NW-1:QB]};
    assign div_d.lane[i].nlo = num[QB-1:0];
    assign div_d.lane[i].quo = '0;
    assign div_d.lane[i].neg = neg6_q[i];
    assign div_d.lane[i].ovf = {32'b0, num[NW-1:QB]} >= {dm6_q, 1'b0};
  end
  assign div_d.den  = {dm6_q, 1'b0};
  assign div_d.sing = sing6_q;
  assign div_d.det  = det6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cof3_q  <= cof_i;
      pl3_q   <= pl_d;
      ph3_q   <= ph_d;
      tneg3_q <= tneg_d;
    end
    if (en[1]) begin
      cof4_q <= cof3_q;
      t4_q   <= t_d;
    end
    if (en[2]) begin
      cof5_q <= cof4_q;
      d5_q   <= t4_q[0] + t4_q[1] + t4_q[2];
    end
    if (en[3]) begin
      cm6_q   <= cm_d;
      neg6_q  <= neg_d;
      dm6_q   <= dabs[DM-1:0];
      sing6_q <= sing_d;
      det6_q  <= det_d;
    end
    if (en[4]) div7_q <= div_d;
  end

endmodule

// ===== rtl/m3i_div_step.sv =====
// One restoring-division step for all nine lanes, one quotient bit each.
// Depends on m3i_pkg.
module m3i_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  m3i_pkg::div_t d_i,
  output logic          valid_o,
  input  logic          ready_i,
  output m3i_pkg::div_t d_o
);

  localparam int unsigned DN = m3i_pkg::DenW;
  localparam int unsigned QB = m3i_pkg::QB;

  logic          v_q, en;
  m3i_pkg::div_t d_q, d_d;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign d_o     = d_q;

  always_comb begin
    logic [DN:0] tmp;
    logic        ge;
    d_d = d_i;
    for (int i = 0; i < 9; i++) begin
      tmp = {d_i.lane[i].rem, d_i.lane[i].nlo[QB-1]};
      ge  = tmp >= {1'b0, d_i.den};
      d_d.lane[i].rem = ge ? DN'(tmp - {1'b0, d_i.den}) : tmp[DN-1:0];
      d_d.lane[i].nlo = {d_i.lane[i].nlo[QB-2:0], 1'b0};
      d_d.lane[i].quo = {d_i.lane[i].quo[QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) d_q <= d_d;
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !d_q.lane[0].ovf |-> d_q.lane[0].rem < d_q.den)
    else $error("division remainder not below divisor");
`endif

endmodule

// ===== rtl/m3i_divider.sv =====
// Chain of division steps, then saturation and the singular select.
// Depends on m3i_pkg and m3i_div_step.
module m3i_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  m3i_pkg::div_t div_i,
  output logic          valid_o,
  input  logic          ready_i,
  output m3i_pkg::res_t res_o
);

  localparam int unsigned QB = m3i_pkg::QB;
  localparam int unsigned W  = m3i_pkg::DW;

  logic [QB:0]          vld, rdy;
  m3i_pkg::div_t [QB:0] dat;
  logic                 v_q, en;
  m3i_pkg::res_t        res_q, res_d;
  m3i_pkg::div_t        fin;

  assign vld[0]  = valid_i;
  assign dat[0]  = div_i;
  assign ready_o = rdy[0];

  for (genvar s = 0; s < QB; s++) begin : g_step
    m3i_div_step u_step (
      .clk_i, .rst_ni,
      .valid_i (vld[s]),
      .ready_o (rdy[s]),
      .d_i     (dat[s]),
      .valid_o (vld[s+1]),
      .ready_i (rdy[s+1]),
      .d_o     (dat[s+1])
    );
  end

  assign en      = !v_q || ready_i;
  assign rdy[QB] = en;
  assign fin     = dat[QB];
  assign valid_o = v_q;
  assign res_o   = res_q;

  always_comb begin
    logic [W-1:0] lim, mag;
    res_d.sing = fin.sing;
    res_d.det  = fin.det;
    for (int i = 0; i < 9; i++) begin
      lim = fin.lane[i].neg ? m3i_pkg::SatNeg : m3i_pkg::SatPos;
      mag = (fin.lane[i].ovf || fin.lane[i].quo > {1'b0, lim})
            ? lim : fin.lane[i].quo[W-1:0];
      if (fin.sing) res_d.b[i] = (i % 4 == 0) ? m3i_pkg::QOne : '0;
      else          res_d.b[i] = fin.lane[i].neg ? (~mag + W'(1)) : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= vld[QB];
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

endmodule

// ===== rtl/matrix3_inverse.sv =====
// Top level of the 3x3 matrix inverse; depends on m3i_pkg, the three channel
// interfaces, m3i_cofactor, m3i_det and m3i_divider.
//
// Usage: each request on in_ch carries one 3x3 matrix of signed Q16.16
// entries. Every request yields exactly one result on out_ch: the inverse
// (b00..b22, rounded to nearest and saturated), the determinant floored to
// Q16.16 and saturated, and the singular flag. When the determinant
// magnitude is at most epsilon the identity comes back with singular set.
// The cfg channel writes epsilon (Q16.16 units); it is always ready and
// should only be written while no request is in flight. Reset sets it to 1.
// A request passes through two stages of products and cofactors, five of
// determinant and operand setup, 33 restoring-division steps (one quotient
// bit per stage, nine lanes), and the output register. A request can enter
// every cycle while the receiver does not stall, so throughput is one
// matrix per cycle. Each stage holds its data while the next one is full, so
// when the receiver stalls the pipeline fills its empty stages first and
// in_ch.ready falls only once every stage holds a request. Reset empties
// the pipeline; no result is lost or repeated across stalls.
module matrix3_inverse (
  input  logic     clk_i,
  input  logic     rst_ni,
  m3i_cfg_if.sink  cfg_ch,
  m3i_in_if.sink   in_ch,
  m3i_out_if.source out_ch
);

  logic [m3i_pkg::EpsW-1:0] eps_q;
  m3i_pkg::mat_t mat;
  m3i_pkg::cof_t cof;
  m3i_pkg::row_t row;
  m3i_pkg::div_t div;
  m3i_pkg::res_t res;
  logic cof_valid, cof_ready, det_valid, det_ready;

  // The epsilon register accepts a write in any cycle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= m3i_pkg::EpsW'(1);
    else if (cfg_ch.valid) eps_q <= cfg_ch.epsilon;
  end

  assign mat = {in_ch.a22, in_ch.a21, in_ch.a20, in_ch.a12, in_ch.a11,
                in_ch.a10, in_ch.a02, in_ch.a01, in_ch.a00};

  m3i_cofactor u_cofactor (
    .clk_i, .rst_ni,
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .mat_i   (mat),
    .valid_o (cof_valid),
    .ready_i (cof_ready),
    .cof_o   (cof),
    .row_o   (row)
  );

  m3i_det u_det (
    .clk_i, .rst_ni,
    .valid_i (cof_valid),
    .ready_o (cof_ready),
    .cof_i   (cof),
    .row_i   (row),
    .eps_i   (eps_q),
    .valid_o (det_valid),
    .ready_i (det_ready),
    .div_o   (div)
  );

  m3i_divider u_divider (
    .clk_i, .rst_ni,
    .valid_i (det_valid),
    .ready_o (det_ready),
    .div_i   (div),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .res_o   (res)
  );

  assign out_ch.b00       = res.b[0];
  assign out_ch.b01       = res.b[1];
  assign out_ch.b02       = res.b[2];
  assign out_ch.b10       = res.b[3];
  assign out_ch.b11       = res.b[4];
  assign out_ch.b12       = res.b[5];
  assign out_ch.b20       = res.b[6];
  assign out_ch.b21       = res.b[7];
  assign out_ch.b22       = res.b[8];
  assign out_ch.singular  = res.sing;
  assign out_ch.det_value = res.det;

`ifndef ASSERT_OFF
  a_singular_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.singular |->
      out_ch.b00 == m3i_pkg::QOne && out_ch.b11 == m3i_pkg::QOne &&
      out_ch.b22 == m3i_pkg::QOne && out_ch.b01 == 0 && out_ch.b02 == 0 &&
      out_ch.b10 == 0 && out_ch.b12 == 0 && out_ch.b20 == 0 && out_ch.b21 == 0)
    else $error("singular result is not the identity");
  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input blocked while output side is not stalled");
  a_eps_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ch.valid |=> eps_q == $past(cfg_ch.epsilon))
    else $error("epsilon write lost");
`endif

endmodule

// ===== dv/tb_matrix3_inverse.sv =====
// Self-checking testbench of the 3x3 matrix inverse: directed and random matrices,
// epsilon settings, random input gaps and random output stalls. Depends on m3i_pkg and the
// three channel interfaces of the block.
module tb_matrix3_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLat   = 41;
  localparam int unsigned IdleLimit = 20000;

  // One expected result: nine inverse entries, the singular flag and the determinant.
  typedef struct {
    logic [8:0][31:0] b;
    logic             sing;
    logic [31:0]      det;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  m3i_cfg_if cfg_ch ();
  m3i_in_if  in_ch ();
  m3i_out_if out_ch ();

  matrix3_inverse u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Testbench copy of the epsilon register and the queue of inverses still due.
  logic [30:0] eps_model = 31'd1;
  inverse_t    inverse_due[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold = 0;  // long receiver hold-off, counted down per cycle

  // Signed p*q - r*s, exact in 65 bits (Q33.32).
  function automatic logic signed [64:0] cof_of(logic signed [31:0] p, logic signed [31:0] q,
                                                logic signed [31:0] r, logic signed [31:0] s);
    logic signed [64:0] pq;
    logic signed [64:0] rs;
    pq = p * q;
    rs = r * s;
    return pq - rs;
  endfunction

  // Predict the block's result for one matrix under the current epsilon.
  function automatic inverse_t predict_inverse(logic [8:0][31:0] a);
    inverse_t res;
    logic signed [64:0] c[9];
    logic signed [127:0] d;
    logic [127:0] dmag;
    logic [127:0] cmag;
    logic [127:0] num;
    logic [127:0] quo;
    logic signed [127:0] dfl;
    logic [31:0] lim;
    logic [31:0] v;
    logic neg;
    for (int i = 0; i < 9; i++) begin
      c[i] = cof_of(a[m3i_pkg::CofSel[i][0]], a[m3i_pkg::CofSel[i][1]],
                    a[m3i_pkg::CofSel[i][2]], a[m3i_pkg::CofSel[i][3]]);
    end
    d = 128'(c[0]) * 128'($signed(a[0])) + 128'(c[3]) * 128'($signed(a[1]))
      + 128'(c[6]) * 128'($signed(a[2]));
    dmag = d[127] ? -d : d;
    // Determinant floored to Q16.16, then saturated.
    dfl = d >>> 32;
    if (dfl > 128'sh7FFF_FFFF) res.det = m3i_pkg::SatPos;
    else if (dfl < -128'sh8000_0000) res.det = m3i_pkg::SatNeg;
    else res.det = dfl[31:0];
    res.sing = (dmag <= ({97'd0, eps_model} << 32));
    for (int i = 0; i < 9; i++) begin
      if (res.sing) begin
        res.b[i] = (i == 0 || i == 4 || i == 8) ? m3i_pkg::QOne : 32'd0;
      end else begin
        // Round to nearest on magnitudes, ties away from zero.
        cmag = c[i][64] ? -128'(c[i]) : 128'(c[i]);
        neg  = c[i][64] != d[127];
        num  = (cmag << 33) + dmag;
        quo  = num / (dmag << 1);
        lim  = neg ? m3i_pkg::SatNeg : m3i_pkg::SatPos;
        v    = (quo > {96'd0, lim}) ? lim : quo[31:0];
        res.b[i] = neg ? -v : v;
      end
    end
    return res;
  endfunction

  // Send one matrix; the expectation is queued when the request is accepted.
  // Valid stays high after the request so that back-to-back requests need no gap.
  task automatic send_matrix(logic [8:0][31:0] a);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a22, in_ch.a21, in_ch.a20, in_ch.a12, in_ch.a11, in_ch.a10,
     in_ch.a02, in_ch.a01, in_ch.a00} <= a;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    inverse_due.push_back(predict_inverse(a));
  endtask

  // Wait for every result, then let the pipeline drain before touching epsilon.
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (inverse_due.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 4) @(posedge clk_i);
  endtask

  task automatic write_epsilon(logic [30:0] value);
    drain_all();
    cfg_ch.valid   <= 1'b1;
    cfg_ch.epsilon <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    eps_model = value;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return 32'($signed($urandom_range(0, 1023)) - 512) << 16;
      3: return $urandom_range(0, 1) ? m3i_pkg::SatPos : m3i_pkg::SatNeg;
      4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return 32'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic logic [8:0][31:0] rand_matrix();
    logic [8:0][31:0] a;
    int unsigned k;
    for (int i = 0; i < 9; i++) a[i] = rand_entry();
    // Some matrices get two equal rows so that the determinant is zero.
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) a[((k + 1) % 3) * 3 + j] = a[k * 3 + j];
    end
    return a;
  endfunction

  // Extremes of the entries, identity, singular and near-singular matrices.
  task automatic test_directed();
    logic [8:0][31:0] a;
    a = '0; send_matrix(a);
    a = '0;
    a[0] = m3i_pkg::QOne; a[4] = m3i_pkg::QOne; a[8] = m3i_pkg::QOne; send_matrix(a);
    a[0] = 32'h0002_0000; a[4] = 32'hFFFE_0000; a[8] = 32'h0000_8000; send_matrix(a);
    a = '{9{m3i_pkg::SatPos}}; send_matrix(a);
    a = '{9{m3i_pkg::SatNeg}}; send_matrix(a);
    a = '0; a[0] = m3i_pkg::SatNeg; a[4] = m3i_pkg::SatNeg; a[8] = m3i_pkg::SatNeg;
    send_matrix(a);
    a = '0; a[0] = m3i_pkg::SatPos; a[4] = m3i_pkg::SatPos; a[8] = m3i_pkg::SatNeg;
    send_matrix(a);
    a = '0; a[0] = 32'd1; a[4] = 32'd1; a[8] = 32'd1; send_matrix(a);
    a = '0; a[0] = 32'd1; a[4] = m3i_pkg::QOne; a[8] = m3i_pkg::QOne; send_matrix(a);
    a = '0; a[2] = m3i_pkg::QOne; a[4] = m3i_pkg::QOne; a[6] = m3i_pkg::QOne;
    send_matrix(a);
    a = '0; a[0] = 32'h0003_0000; a[4] = 32'h0003_0000; a[8] = 32'h0003_0000;
    send_matrix(a);
    a = '0; a[0] = 32'h0100_0000; a[4] = 32'h0100_0000; a[8] = 32'h0100_0000;
    send_matrix(a);
    a = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8, 32'hA};
    send_matrix(a);
    a = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
          32'hFFFF_FFFF};
    send_matrix(a);
    for (int i = 0; i < 6; i++) send_matrix(rand_matrix());
    drain_all();
  endtask

  // Epsilon settings, the extremes among them, each followed by a burst of matrices.
  task automatic test_epsilon();
    logic [30:0] eps_list[5];
    logic [8:0][31:0] a;
    eps_list = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd12345, 31'd1};
    foreach (eps_list[e]) begin
      write_epsilon(eps_list[e]);
      a = '0; a[0] = 32'd1; a[4] = 32'd1; a[8] = 32'd1; send_matrix(a);
      a = '0; a[0] = m3i_pkg::QOne; a[4] = m3i_pkg::QOne; a[8] = m3i_pkg::QOne;
      send_matrix(a);
      for (int i = 0; i < 40; i++) send_matrix(rand_matrix());
    end
    write_epsilon(31'($urandom() & 32'h0000_FFFF));
  endtask

  // Receiver holds off for a long stretch while matrices keep coming, then the
  // sender pauses until the pipeline is empty.
  task automatic test_backpressure();
    sink_hold = 200;
    for (int i = 0; i < 80; i++) send_matrix(rand_matrix());
    in_ch.valid <= 1'b0;
    while (inverse_due.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 20; i++) send_matrix(rand_matrix());
  endtask

  task automatic test_random();
    for (int i = 0; i < 1150; i++) send_matrix(rand_matrix());
    // Last part of the run without any idling.
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    for (int i = 0; i < 150; i++) send_matrix(rand_matrix());
  endtask

  // Receiver: random stall bursts, plus the long hold-off.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (sink_hold != 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checker: every accepted result is compared with the oldest expectation.
  initial begin
    inverse_t exp_res;
    logic [8:0][31:0] got_b;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got_b = {out_ch.b22, out_ch.b21, out_ch.b20, out_ch.b12, out_ch.b11,
                 out_ch.b10, out_ch.b02, out_ch.b01, out_ch.b00};
        if (inverse_due.size() == 0) begin
          $display("%0t: unexpected result, det %h", $time, out_ch.det_value);
          err_cnt++;
        end else begin
          exp_res = inverse_due.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (got_b[i] !== exp_res.b[i]) begin
              $display("%0t: b%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                       exp_res.b[i], got_b[i]);
              err_cnt++;
            end
          end
          if (out_ch.singular !== exp_res.sing) begin
            $display("%0t: singular expected %b actual %b", $time, exp_res.sing,
                     out_ch.singular);
            err_cnt++;
          end
          if (out_ch.det_value !== exp_res.det) begin
            $display("%0t: det_value expected %h actual %h", $time, exp_res.det,
                     out_ch.det_value);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_matrix3_inverse: done, errors");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.a00 <= '0; in_ch.a01 <= '0; in_ch.a02 <= '0;
    in_ch.a10 <= '0; in_ch.a11 <= '0; in_ch.a12 <= '0;
    in_ch.a20 <= '0; in_ch.a21 <= '0; in_ch.a22 <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.epsilon <= 31'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_epsilon();
    test_backpressure();
    test_random();
    drain_all();
    if (err_cnt == 0) begin
      $display("tb_matrix3_inverse: done, clean");
    end else begin
      $display("tb_matrix3_inverse: done, errors");
    end
    $finish;
  end

endmodule
